[sv/rlcs_pkg.sv]
// Shared constants, types and helpers for the real literal and comment scanner.
`timescale 1ns / 1ps

package rlcs_pkg;

    localparam int unsigned          MAX_NESTING = 255;
    localparam longint unsigned      MAX_LENGTH  = 64'd65535;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned DEPTH_W = $clog2(MAX_NESTING + 1);

    typedef logic [CP_W-1:0]    cp_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [DEPTH_W-1:0] depth_t;

    // Lengths and counts stop at the smaller of MAX_LENGTH and the field range.
    localparam count_t LEN_CAP =
        CNT_W'((MAX_LENGTH < 64'd65535) ? MAX_LENGTH : 64'd65535);
    localparam depth_t DEPTH_CAP = DEPTH_W'(MAX_NESTING);

    // Token kinds
    localparam kind_t KIND_COMMENT = 2'd0;
    localparam kind_t KIND_STRING  = 2'd1;
    localparam kind_t KIND_CHAR    = 2'd2;
    localparam kind_t KIND_REAL    = 2'd3;

    // Characters of interest
    localparam cp_t CH_DQUOTE    = 21'd34;
    localparam cp_t CH_SQUOTE    = 21'd39;
    localparam cp_t CH_CARET     = 21'd94;
    localparam cp_t CH_BACKSLASH = 21'd92;
    localparam cp_t CH_NEWLINE   = 21'd10;
    localparam cp_t CH_UNDERLINE = 21'd95;
    localparam cp_t CH_DOT       = 21'd46;
    localparam cp_t CH_LOWER_E   = 21'd101;
    localparam cp_t CH_UPPER_E   = 21'd69;
    localparam cp_t CH_STAR      = 21'd42;
    localparam cp_t CH_SLASH     = 21'd47;
    localparam cp_t CH_PLUS      = 21'd43;
    localparam cp_t CH_MINUS     = 21'd45;
    localparam cp_t CH_SPACE     = 21'd32;
    localparam cp_t CH_TAB       = 21'd9;
    localparam cp_t CH_CR        = 21'd13;
    localparam cp_t CH_ZERO      = 21'd48;
    localparam cp_t CH_NINE      = 21'd57;
    localparam cp_t CH_NUL       = 21'd0;

    function automatic count_t inc_sat(input count_t v);
        return (v < LEN_CAP) ? count_t'(v + count_t'(1)) : v;
    endfunction

endpackage

[sv/rlcs_if.sv]
// Valid/ready channel interfaces for scanner characters and token results.
`timescale 1ns / 1ps

interface rlcs_char_if
    import rlcs_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  starts_scan;
    logic  want_string;
    logic  want_char;
    logic  want_real;
    cp_t   code_point;
    logic  at_end;

    modport source (output valid, starts_scan, want_string, want_char, want_real,
                    code_point, at_end, input ready);
    modport sink   (input valid, starts_scan, want_string, want_char, want_real,
                    code_point, at_end, output ready);
endinterface

interface rlcs_token_if
    import rlcs_pkg::*;
;
    logic   valid;
    logic   ready;
    kind_t  token_kind;
    logic   accepted;
    count_t token_length;
    count_t skipped_space;

    modport source (output valid, token_kind, accepted, token_length, skipped_space,
                    input ready);
    modport sink   (input valid, token_kind, accepted, token_length, skipped_space,
                    output ready);
endinterface

[sv/real_literal_and_comment_scanner.sv]
// Top level of the real literal and nested block comment scanner.
`timescale 1ns / 1ps

// Usage
// -----
// chars  : one character item per handshake. An item with starts_scan set opens a
//          new scan and latches want_string / want_char / want_real; it drops any
//          scan still running. at_end marks the end of input (code point reads as 0).
// tokens : one result item when a scan ends: token_kind, accepted, token_length
//          (0 when rejected) and skipped_space, both lengths saturating.
// The scan state is updated at the edge that accepts a character item, and a result
// caused by it shows on tokens in the next cycle from the output register. One item
// can be accepted every cycle while chars.ready is high.
// The output register is the only buffer: while it holds a result the receiver has
// not taken, chars.ready drops and the scan state holds.
// Items with starts_scan clear while no scan runs are taken and dropped.
// Reset clears the scan state to idle and empties the output register; no result
// is pending afterwards.

module real_literal_and_comment_scanner
    import rlcs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rlcs_char_if.sink     chars,
    rlcs_token_if.source  tokens
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_STR      = 4'd1;
    localparam logic [3:0] PH_CHR      = 4'd2;
    localparam logic [3:0] PH_SPACE    = 4'd3;
    localparam logic [3:0] PH_INT      = 4'd4;
    localparam logic [3:0] PH_DOT      = 4'd5;
    localparam logic [3:0] PH_FRAC     = 4'd6;
    localparam logic [3:0] PH_EXP      = 4'd7;
    localparam logic [3:0] PH_SIGN     = 4'd8;
    localparam logic [3:0] PH_EXPDIG   = 4'd9;
    localparam logic [3:0] PH_SLASH    = 4'd10;
    localparam logic [3:0] PH_CMT      = 4'd11;
    localparam logic [3:0] PH_CMTSLASH = 4'd12;

    // Scan state
    logic [3:0] phase_reg,      phase_next;
    depth_t     depth_reg,      depth_next;
    logic       star_reg,       star_next;
    logic       lead_reg,       lead_next;
    logic       frac_reg,       frac_next;
    count_t     consumed_reg,   consumed_next;
    count_t     marked_reg,     marked_next;
    count_t     space_reg,      space_next;
    logic [2:0] wants_reg,      wants_next;

    // Output register
    logic       out_valid_reg,  out_valid_next;
    kind_t      kind_reg,       kind_next;
    logic       ok_reg,         ok_next;
    count_t     len_reg,        len_next;
    count_t     skip_reg,       skip_next;

    // Effective state once a scan start has been applied
    logic [3:0] ph;
    depth_t     dep;
    logic       star;
    logic       lead;
    logic       frac;
    count_t     cons;
    count_t     mark;
    count_t     spc;
    logic [2:0] wants;

    logic       accept;
    logic       fire;
    kind_t      fire_kind;
    logic       fire_ok;
    count_t     fire_len;
    cp_t        c;
    logic       is_space;
    logic       is_digit;
    count_t     cons_inc;

    assign chars.ready = !out_valid_reg || tokens.ready;
    assign accept      = chars.valid && chars.ready;

    assign c        = chars.at_end ? CH_NUL : chars.code_point;
    assign is_space = (c inside {CH_SPACE, [CH_TAB:CH_CR]});
    assign is_digit = (c inside {CH_UNDERLINE, [CH_ZERO:CH_NINE]});

    // Apply a scan start: clear the scan state and pick the first phase
    always_comb
    begin
        ph    = phase_reg;
        dep   = depth_reg;
        star  = star_reg;
        lead  = lead_reg;
        frac  = frac_reg;
        cons  = consumed_reg;
        mark  = marked_reg;
        spc   = space_reg;
        wants = wants_reg;
        if (chars.starts_scan)
        begin
            dep   = '0;
            star  = 1'b0;
            lead  = 1'b0;
            frac  = 1'b0;
            cons  = '0;
            mark  = '0;
            spc   = '0;
            wants = {chars.want_real, chars.want_char, chars.want_string};
            if (chars.want_string && !chars.want_real)
                ph = PH_STR;
            else if (chars.want_char && !chars.want_real)
                ph = PH_CHR;
            else
                ph = PH_SPACE;
        end
    end

    assign cons_inc = inc_sat(cons);

    // One step of the scan on the lookahead character
    always_comb
    begin
        phase_next    = ph;
        depth_next    = dep;
        star_next     = star;
        lead_next     = lead;
        frac_next     = frac;
        consumed_next = cons;
        marked_next   = mark;
        space_next    = spc;
        wants_next    = wants;
        fire          = 1'b0;
        fire_kind     = KIND_COMMENT;
        fire_ok       = 1'b0;
        fire_len      = '0;

        case (ph)
            PH_STR, PH_CHR:
            begin
                if (c == ((ph == PH_STR) ? CH_DQUOTE : CH_SQUOTE) || c == CH_BACKSLASH
                    || c == CH_CARET || c == CH_NEWLINE)
                begin
                    fire      = 1'b1;
                    fire_kind = (ph == PH_STR) ? KIND_STRING : KIND_CHAR;
                    fire_ok   = (cons != '0);
                    fire_len  = cons;
                end
                else if (chars.at_end)
                begin
                    fire      = 1'b1;
                    fire_kind = (ph == PH_STR) ? KIND_STRING : KIND_CHAR;
                end
                else
                begin
                    consumed_next = cons_inc;
                end
            end
            PH_SPACE:
            begin
                if (is_space)
                begin
                    space_next = inc_sat(spc);
                end
                else if (wants[2] && (is_digit || c == CH_DOT))
                begin
                    consumed_next = cons_inc;
                    if (c == CH_DOT)
                    begin
                        phase_next = PH_DOT;
                    end
                    else
                    begin
                        lead_next  = 1'b1;
                        phase_next = PH_INT;
                    end
                end
                else if (c == CH_SLASH)
                begin
                    consumed_next = cons_inc;
                    phase_next    = PH_SLASH;
                end
                else
                begin
                    fire      = 1'b1;
                    fire_kind = KIND_COMMENT;
                end
            end
            PH_INT, PH_DOT, PH_FRAC:
            begin
                fire_kind = KIND_REAL;
                if (ph == PH_DOT && c == CH_DOT)
                begin
                    fire = 1'b1;
                end
                else if (is_digit)
                begin
                    consumed_next = cons_inc;
                    if (ph == PH_DOT)
                    begin
                        frac_next  = 1'b1;
                        phase_next = PH_FRAC;
                    end
                end
                else if (ph == PH_INT && c == CH_DOT)
                begin
                    consumed_next = cons_inc;
                    phase_next    = PH_DOT;
                end
                else
                begin
                    // Mantissa ended: mark it; no digits rejects; else take an 'e' or accept if fractional
                    marked_next = cons;
                    if (!frac && !lead)
                    begin
                        fire = 1'b1;
                    end
                    else if (c == CH_LOWER_E || c == CH_UPPER_E)
                    begin
                        consumed_next = cons_inc;
                        phase_next    = PH_EXP;
                    end
                    else
                    begin
                        fire     = 1'b1;
                        fire_ok  = frac;
                        fire_len = frac ? cons : '0;
                    end
                end
            end
            PH_EXP, PH_SIGN:
            begin
                if (ph == PH_EXP && (c == CH_PLUS || c == CH_MINUS))
                begin
                    consumed_next = cons_inc;
                    phase_next    = PH_SIGN;
                end
                else if (is_digit)
                begin
                    consumed_next = cons_inc;
                    phase_next    = PH_EXPDIG;
                end
                else
                begin
                    // Dangling exponent: keep the length before the 'e'
                    fire      = 1'b1;
                    fire_kind = KIND_REAL;
                    fire_ok   = 1'b1;
                    fire_len  = mark;
                end
            end
            PH_EXPDIG:
            begin
                if (is_digit)
                begin
                    consumed_next = cons_inc;
                end
                else
                begin
                    fire      = 1'b1;
                    fire_kind = KIND_REAL;
                    fire_ok   = 1'b1;
                    fire_len  = cons;
                end
            end
            PH_SLASH:
            begin
                if (c != CH_STAR)
                begin
                    fire      = 1'b1;
                    fire_kind = KIND_COMMENT;
                end
                else
                begin
                    consumed_next = cons_inc;
                    depth_next    = depth_t'(1);
                    star_next     = 1'b0;
                    phase_next    = PH_CMT;
                end
            end
            PH_CMT, PH_CMTSLASH:
            begin
                if (ph == PH_CMTSLASH && c == CH_STAR)
                begin
                    // Nested opener
                    consumed_next = cons_inc;
                    if (dep < DEPTH_CAP)
                        depth_next = depth_t'(dep + depth_t'(1));
                    star_next  = 1'b0;
                    phase_next = PH_CMT;
                end
                else
                begin
                    phase_next = PH_CMT;
                    if (c == CH_NUL)
                    begin
                        fire      = 1'b1;
                        fire_kind = KIND_COMMENT;
                    end
                    else
                    begin
                        consumed_next = cons_inc;
                        if (c == CH_STAR)
                        begin
                            star_next = 1'b1;
                        end
                        else if (c == CH_SLASH)
                        begin
                            if (star)
                            begin
                                star_next = 1'b0;
                                if (dep > depth_t'(1))
                                begin
                                    depth_next = depth_t'(dep - depth_t'(1));
                                end
                                else
                                begin
                                    // Outermost closer
                                    depth_next = '0;
                                    fire       = 1'b1;
                                    fire_kind  = KIND_COMMENT;
                                    fire_ok    = 1'b1;
                                    fire_len   = cons_inc;
                                end
                            end
                            else
                            begin
                                phase_next = PH_CMTSLASH;
                            end
                        end
                        else
                        begin
                            star_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (fire)
            phase_next = PH_IDLE;
    end

    // Load the output register on a result, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        ok_next        = ok_reg;
        len_next       = len_reg;
        skip_next      = skip_reg;
        if (tokens.ready)
            out_valid_next = 1'b0;
        if (accept && fire)
        begin
            out_valid_next = 1'b1;
            kind_next      = fire_kind;
            ok_next        = fire_ok;
            len_next       = fire_len;
            skip_next      = spc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            depth_reg     <= '0;
            star_reg      <= 1'b0;
            lead_reg      <= 1'b0;
            frac_reg      <= 1'b0;
            consumed_reg  <= '0;
            marked_reg    <= '0;
            space_reg     <= '0;
            wants_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg    <= phase_next;
                depth_reg    <= depth_next;
                star_reg     <= star_next;
                lead_reg     <= lead_next;
                frac_reg     <= frac_next;
                consumed_reg <= consumed_next;
                marked_reg   <= marked_next;
                space_reg    <= space_next;
                wants_reg    <= wants_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        ok_reg   <= ok_next;
        len_reg  <= len_next;
        skip_reg <= skip_next;
    end

    assign tokens.valid         = out_valid_reg;
    assign tokens.token_kind    = kind_reg;
    assign tokens.accepted      = ok_reg;
    assign tokens.token_length  = len_reg;
    assign tokens.skipped_space = skip_reg;

    // A rejected token never carries a length
    a_reject_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !ok_reg |-> len_reg == '0)
        else $error("rejected token with nonzero length");

    // Accepted content tokens are never empty
    a_content_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ok_reg && (kind_reg == KIND_STRING || kind_reg == KIND_CHAR)
        |-> len_reg != '0)
        else $error("accepted empty content token");

    // Inside a comment the nesting depth is at least one
    a_comment_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CMT || phase_reg == PH_CMTSLASH) |-> depth_reg != '0)
        else $error("comment phase with zero nesting depth");

    // A result caused by an accepted item shows in the next cycle
    a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && fire |=> out_valid_reg)
        else $error("result lost after accepted item");

endmodule

[bench/real_literal_and_comment_scanner_tb.sv]
// Self-checking testbench for the real literal and block comment scanner.
`timescale 1ns / 1ps

import rlcs_pkg::*;

typedef enum logic [3:0] {
    P_IDLE,
    P_STR,
    P_CHR,
    P_SPACE,
    P_INT,
    P_DOT,
    P_FRAC,
    P_EXP,
    P_SIGN,
    P_EXPDIG,
    P_SLASH,
    P_CMT,
    P_CMTSLASH
} scan_phase_t;

typedef struct {
    logic       start;
    logic [2:0] wants;    // [0] string, [1] char, [2] real
    cp_t        cp;
    logic       at_end;
} char_item_t;

typedef struct {
    kind_t  kind;
    logic   ok;
    count_t length;
    count_t spaces;
} token_t;

// Tracks the scan state of the block and the tokens it owes.
class token_scoreboard;
    scan_phase_t phase;
    int unsigned nest;
    bit          star_seen;
    bit          int_digits;
    bit          frac_digits;
    count_t      taken;
    count_t      mark;
    count_t      blanks;
    logic [2:0]  wants;
    token_t      expected_q[$];
    int          errors;

    function new();
        errors = 0;
        restart(3'b000);
        phase = P_IDLE;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void restart(logic [2:0] w);
        nest        = 0;
        star_seen   = 1'b0;
        int_digits  = 1'b0;
        frac_digits = 1'b0;
        taken       = '0;
        mark        = '0;
        blanks      = '0;
        wants       = w;
        if (w[0] && !w[2])
            phase = P_STR;
        else if (w[1] && !w[2])
            phase = P_CHR;
        else
            phase = P_SPACE;
    endfunction

    function count_t bump(count_t v);
        return (v < LEN_CAP) ? count_t'(v + 1'b1) : v;
    endfunction

    function bit is_blank(cp_t c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function bit is_digit(cp_t c);
        return c == CH_UNDERLINE || (c >= CH_ZERO && c <= CH_NINE);
    endfunction

    function void emit(kind_t k, bit ok, count_t len);
        token_t t;
        t.kind   = k;
        t.ok     = ok;
        t.length = ok ? len : '0;
        t.spaces = blanks;
        expected_q.push_back(t);
        phase = P_IDLE;
    endfunction

    function void content_step(cp_t c, bit fin, cp_t quote, kind_t k);
        if (c == quote || c == CH_BACKSLASH || c == CH_CARET || c == CH_NEWLINE)
            emit(k, taken != 0, taken);
        else if (fin)
            emit(k, 1'b0, '0);
        else
            taken = bump(taken);
    endfunction

    // Character after the mantissa: an exponent may follow, else decide.
    function void number_end(cp_t c);
        mark = taken;
        if (!frac_digits && !int_digits)
            emit(KIND_REAL, 1'b0, '0);
        else if (c == CH_LOWER_E || c == CH_UPPER_E)
        begin
            taken = bump(taken);
            phase = P_EXP;
        end
        else if (!frac_digits)
            emit(KIND_REAL, 1'b0, '0);
        else
            emit(KIND_REAL, 1'b1, mark);
    endfunction

    function void comment_step(cp_t c);
        phase = P_CMT;
        if (c == CH_NUL)
            emit(KIND_COMMENT, 1'b0, '0);
        else
        begin
            taken = bump(taken);
            if (c == CH_STAR)
                star_seen = 1'b1;
            else if (c == CH_SLASH)
            begin
                if (star_seen)
                begin
                    star_seen = 1'b0;
                    if (nest > 0)
                        nest--;
                    if (nest == 0)
                        emit(KIND_COMMENT, 1'b1, taken);
                end
                else
                    phase = P_CMTSLASH;
            end
            else
                star_seen = 1'b0;
        end
    endfunction

    // Advance the scan by one accepted character item.
    function void take_char(char_item_t it);
        cp_t c;
        c = it.at_end ? CH_NUL : it.cp;
        if (it.start)
            restart(it.wants);
        case (phase)
            P_IDLE: ;
            P_STR: content_step(c, it.at_end, CH_DQUOTE, KIND_STRING);
            P_CHR: content_step(c, it.at_end, CH_SQUOTE, KIND_CHAR);
            P_SPACE:
                if (is_blank(c))
                    blanks = bump(blanks);
                else if (wants[2] && (is_digit(c) || c == CH_DOT))
                begin
                    taken = bump(taken);
                    if (c == CH_DOT)
                        phase = P_DOT;
                    else
                    begin
                        int_digits = 1'b1;
                        phase      = P_INT;
                    end
                end
                else if (c == CH_SLASH)
                begin
                    taken = bump(taken);
                    phase = P_SLASH;
                end
                else
                    emit(KIND_COMMENT, 1'b0, '0);
            P_INT:
                if (is_digit(c))
                    taken = bump(taken);
                else if (c == CH_DOT)
                begin
                    taken = bump(taken);
                    phase = P_DOT;
                end
                else
                    number_end(c);
            P_DOT:
                if (c == CH_DOT)
                    emit(KIND_REAL, 1'b0, '0);
                else if (is_digit(c))
                begin
                    taken       = bump(taken);
                    frac_digits = 1'b1;
                    phase       = P_FRAC;
                end
                else
                    number_end(c);
            P_FRAC:
                if (is_digit(c))
                    taken = bump(taken);
                else
                    number_end(c);
            P_EXP:
                if (c == CH_PLUS || c == CH_MINUS)
                begin
                    taken = bump(taken);
                    phase = P_SIGN;
                end
                else if (is_digit(c))
                begin
                    taken = bump(taken);
                    phase = P_EXPDIG;
                end
                else
                    emit(KIND_REAL, 1'b1, mark);
            P_SIGN:
                if (is_digit(c))
                begin
                    taken = bump(taken);
                    phase = P_EXPDIG;
                end
                else
                    emit(KIND_REAL, 1'b1, mark);
            P_EXPDIG:
                if (is_digit(c))
                    taken = bump(taken);
                else
                    emit(KIND_REAL, 1'b1, taken);
            P_SLASH:
                if (c != CH_STAR)
                    emit(KIND_COMMENT, 1'b0, '0);
                else
                begin
                    taken     = bump(taken);
                    nest      = 1;
                    star_seen = 1'b0;
                    phase     = P_CMT;
                end
            P_CMTSLASH:
                if (c == CH_STAR)
                begin
                    taken = bump(taken);
                    if (nest < MAX_NESTING)
                        nest++;
                    star_seen = 1'b0;
                    phase     = P_CMT;
                end
                else
                    comment_step(c);
            P_CMT: comment_step(c);
            default: phase = P_IDLE;
        endcase
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_token(token_t got);
        token_t want;
        if (expected_q.size() == 0)
            report($sformatf("token with nothing expected: kind %0d ok %0b len %0d skip %0d",
                             got.kind, got.ok, got.length, got.spaces));
        else
        begin
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("token_kind %0d, expected %0d", got.kind, want.kind));
            if (got.ok !== want.ok)
                report($sformatf("accepted %0b, expected %0b", got.ok, want.ok));
            if (got.length !== want.length)
                report($sformatf("token_length %0d, expected %0d", got.length, want.length));
            if (got.spaces !== want.spaces)
                report($sformatf("skipped_space %0d, expected %0d", got.spaces, want.spaces));
        end
    endtask
endclass

module real_literal_and_comment_scanner_tb;

    // Want flag masks, bit order as in char_item_t
    localparam logic [2:0] WANT_NONE   = 3'b000;
    localparam logic [2:0] WANT_STRING = 3'b001;
    localparam logic [2:0] WANT_CHAR   = 3'b010;
    localparam logic [2:0] WANT_REAL   = 3'b100;

    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int PHASE_ITEMS  = 92;    // minimum random items per random phase
    localparam int DRAIN_CYCLES = 20;    // settle time after the last token

    logic clk;
    logic rst_n;

    rlcs_char_if  chars_bus ();
    rlcs_token_if tokens_bus ();

    real_literal_and_comment_scanner dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_bus),
        .tokens (tokens_bus)
    );

    token_scoreboard sb;
    char_item_t      stim_q[$];     // character items waiting to be offered
    bit              next_start;    // the next pushed item opens a scan
    logic [2:0]      next_wants;
    int              idle_pct;      // sender: chance of an idle cycle per item
    int              stall_pct;     // receiver: chance of a stall per cycle
    bit              hold_asked;    // request a long receiver hold-off

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hard stop in case the block hangs; the real run is far shorter.
    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // -----------------------------------------------------------------
    // Monitor. Nothing is driven between a falling edge and the next
    // rising edge, so the values seen here are exactly the ones the
    // block samples at that rising edge: a handshake seen now is the
    // item that edge moves.
    // -----------------------------------------------------------------
    always @(negedge clk)
    begin
        char_item_t it;
        token_t     got;
        if (rst_n)
        begin
            if (chars_bus.valid && chars_bus.ready)
            begin
                it.start  = chars_bus.starts_scan;
                it.wants  = {chars_bus.want_real, chars_bus.want_char, chars_bus.want_string};
                it.cp     = chars_bus.code_point;
                it.at_end = chars_bus.at_end;
                sb.take_char(it);
            end
            if (tokens_bus.valid && tokens_bus.ready)
            begin
                got.kind   = tokens_bus.token_kind;
                got.ok     = tokens_bus.accepted;
                got.length = tokens_bus.token_length;
                got.spaces = tokens_bus.skipped_space;
                sb.check_token(got);
            end
        end
    end

    // -----------------------------------------------------------------
    // Receiver. Stall at random per cycle; on request hold ready low for
    // a long stretch so the output register fills and chars.ready drops.
    // One assignment to ready per clock edge.
    // -----------------------------------------------------------------
    initial
    begin
        int held;
        tokens_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked)
            begin
                hold_asked = 1'b0;
                tokens_bus.ready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++)
                begin
                    @(posedge clk);
                    tokens_bus.ready <= 1'b0;
                end
                @(posedge clk);
            end
            tokens_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // -----------------------------------------------------------------
    // Stimulus building: items land in stim_q; the first item after
    // open_scan carries starts_scan and the wanted flags, the rest carry
    // random want bits that the block must ignore.
    // -----------------------------------------------------------------
    function automatic void open_scan(logic [2:0] w);
        next_start = 1'b1;
        next_wants = w;
    endfunction

    function automatic void push_cp(cp_t c, bit fin = 1'b0);
        char_item_t it;
        it.start  = next_start;
        it.wants  = next_start ? next_wants : 3'($urandom_range(7));
        it.cp     = c;
        it.at_end = fin;
        next_start = 1'b0;
        stim_q.push_back(it);
    endfunction

    // End of input: the code point is don't-care, so randomize it.
    function automatic void push_end();
        push_cp(cp_t'($urandom_range(21'h10FFFF)), 1'b1);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_cp(cp_t'(s[i]));
    endfunction

    function automatic void scan_text(logic [2:0] w, string s);
        open_scan(w);
        push_text(s);
    endfunction

    function automatic cp_t any_cp();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return cp_t'($urandom_range(32, 126));
            5, 6:          return cp_t'($urandom_range(127));
            7, 8:          return cp_t'($urandom_range(21'h10FFFF));
            default:       return $urandom_range(1) ? cp_t'(21'h10FFFF)
                                                    : (21'h100000 | cp_t'($urandom_range(127)));
        endcase
    endfunction

    function automatic cp_t blank_cp();
        return $urandom_range(4) == 0 ? CH_SPACE : cp_t'($urandom_range(CH_TAB, CH_CR));
    endfunction

    function automatic cp_t digit_cp();
        return $urandom_range(6) == 0 ? CH_UNDERLINE : cp_t'($urandom_range(CH_ZERO, CH_NINE));
    endfunction

    // Mantissa, optional fraction and exponent, then some terminator.
    function automatic void real_body();
        repeat ($urandom_range(3))
            push_cp(digit_cp());
        if ($urandom_range(9) < 6)
        begin
            push_cp(CH_DOT);
            if ($urandom_range(11) == 0)
                push_cp(CH_DOT);
            repeat ($urandom_range(3))
                push_cp(digit_cp());
        end
        if ($urandom_range(9) < 4)
        begin
            push_cp($urandom_range(1) ? CH_LOWER_E : CH_UPPER_E);
            if ($urandom_range(1))
                push_cp($urandom_range(1) ? CH_PLUS : CH_MINUS);
            repeat ($urandom_range(2))
                push_cp(digit_cp());
        end
        case ($urandom_range(5))
            0: push_cp(CH_SPACE);
            1: push_text(";");
            2: push_end();
            3: push_cp(any_cp());
            4: push_cp(CH_DOT);
            default: push_cp(CH_LOWER_E);
        endcase
    endfunction

    // Block comment with random nesting; mostly closed, sometimes cut off or with a broken opener.
    function automatic void comment_body();
        int d;
        push_cp(CH_SLASH);
        if ($urandom_range(7) == 0)
        begin
            push_cp(any_cp());
            return;
        end
        push_cp(CH_STAR);
        d = 1;
        repeat ($urandom_range(8))
        begin
            case ($urandom_range(5))
                0:
                begin
                    push_text("/*");
                    d++;
                end
                1:
                    if (d > 1)
                    begin
                        push_text("*/");
                        d--;
                    end
                2: push_cp(CH_STAR);
                3: push_cp(CH_SLASH);
                default: push_cp(any_cp());
            endcase
        end
        case ($urandom_range(5))
            0: push_end();
            1: push_cp(CH_NUL);
            default:
                repeat (d)
                    push_text("*/");
        endcase
    endfunction

    function automatic void random_scan();
        logic [2:0] w;
        int         r;
        w = 3'($urandom_range(7));
        r = $urandom_range(99);
        if (r < 40)
            w[2] = 1'b1;                // lean toward real literals
        else if (r < 60)
            w = 3'($urandom_range(3));  // content or comment only
        open_scan(w);
        if ((w[0] || w[1]) && !w[2])
        begin
            repeat ($urandom_range(6))
                push_cp(any_cp());
            case ($urandom_range(9))
                0: push_cp(CH_BACKSLASH);
                1: push_cp(CH_CARET);
                2: push_cp(CH_NEWLINE);
                3: push_end();
                4:
                begin
                    // the other quote is plain content here
                    push_cp(w[0] ? CH_SQUOTE : CH_DQUOTE);
                    push_cp(w[0] ? CH_DQUOTE : CH_SQUOTE);
                end
                5: ;                    // leave it open; the next scan drops it
                default: push_cp(w[0] ? CH_DQUOTE : CH_SQUOTE);
            endcase
        end
        else
        begin
            if ($urandom_range(2) == 0)
                repeat ($urandom_range(1, 4))
                    push_cp(blank_cp());
            if (w[2] && $urandom_range(3) != 0)
                real_body();
            else if ($urandom_range(4) != 0)
                comment_body();
            else
                push_cp(any_cp());
        end
        // stray item, dropped by the block when the scan has ended
        if ($urandom_range(9) == 0)
            push_cp(any_cp());
    endfunction

    function automatic void directed_scans();
        // string and char content: each closer, empty content, end of input
        scan_text(WANT_STRING, "abc\"");
        scan_text(WANT_STRING, "\"");
        scan_text(WANT_STRING, "ab");
        push_end();
        scan_text(WANT_CHAR | WANT_STRING, "q^");
        scan_text(WANT_CHAR, "a\"b\\");
        scan_text(WANT_CHAR, "z\n");
        scan_text(WANT_CHAR, "'");
        open_scan(WANT_STRING);
        push_cp(21'h10FFFF);
        push_cp(CH_NUL);
        push_cp(CH_DQUOTE);
        // restart drops the open scan; then an item while idle is ignored
        scan_text(WANT_STRING, "ab");
        scan_text(WANT_STRING, "cd\"");
        push_cp(CH_SLASH);
        // real literals: accepted forms, bare integer, lone dot, double dot
        scan_text(WANT_REAL | WANT_STRING, " \t1.5;");
        scan_text(WANT_REAL, "12 ");
        scan_text(WANT_REAL, ". ");
        scan_text(WANT_REAL, "1..");
        scan_text(WANT_REAL, "..");
        scan_text(WANT_REAL, "1e;");
        scan_text(WANT_REAL, "2.5E+x");
        scan_text(WANT_REAL, "1_0.2_5e-1_0 ");
        scan_text(WANT_REAL | WANT_CHAR | WANT_STRING, "3.e5 ");
        scan_text(WANT_REAL, ".5");
        push_end();
        // block comments: nesting, every ASCII blank, broken openers, cut off
        scan_text(WANT_NONE, "/* a /* b */ c */");
        open_scan(WANT_CHAR | WANT_REAL);
        for (cp_t b = CH_TAB; b <= CH_CR; b++)
            push_cp(b);
        push_text(" /*/ */");
        scan_text(WANT_NONE, "/x");
        scan_text(WANT_NONE, "x");
        scan_text(WANT_NONE, "/* ab");
        push_end();
        scan_text(WANT_NONE, "/*");
        push_cp(CH_NUL);
        scan_text(WANT_REAL, "/**/");
        // wide code points are never blanks or digits
        open_scan(WANT_NONE);
        push_cp(21'h0000A0);
        open_scan(WANT_NONE);
        push_cp(21'h100020);
        open_scan(WANT_REAL);
        push_cp(21'h100030);
    endfunction

    // -----------------------------------------------------------------
    // Sender. Offer one item: idle first at the configured rate, raise
    // valid with the payload, hold until ready is seen, then return in
    // the time step of the accepting edge.
    // -----------------------------------------------------------------
    task automatic send_item(char_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            chars_bus.valid <= 1'b0;
            @(posedge clk);
        end
        chars_bus.valid       <= 1'b1;
        chars_bus.starts_scan <= it.start;
        chars_bus.want_string <= it.wants[0];
        chars_bus.want_char   <= it.wants[1];
        chars_bus.want_real   <= it.wants[2];
        chars_bus.code_point  <= it.cp;
        chars_bus.at_end      <= it.at_end;
        do
            @(negedge clk);
        while (!chars_bus.ready);
        @(posedge clk);
    endtask

    // Drain the queue, then drop valid so that no item is offered twice
    // and the next raise falls in a later time step.
    task automatic send_queue();
        while (stim_q.size() != 0)
            send_item(stim_q.pop_front());
        chars_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(int sender_pct, int receiver_pct);
        idle_pct  = sender_pct;
        stall_pct = receiver_pct;
        while (stim_q.size() < PHASE_ITEMS)
            random_scan();
        send_queue();
    endtask

    // -----------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------
    initial
    begin
        sb         = new();
        next_start = 1'b0;
        next_wants = WANT_NONE;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_asked = 1'b0;

        rst_n                 <= 1'b0;
        chars_bus.valid       <= 1'b0;
        chars_bus.starts_scan <= 1'b0;
        chars_bus.want_string <= 1'b0;
        chars_bus.want_char   <= 1'b0;
        chars_bus.want_real   <= 1'b0;
        chars_bus.code_point  <= CH_NUL;
        chars_bus.at_end      <= 1'b0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases at full rate
        directed_scans();
        send_queue();
        wait_drained();

        // Full rate random, then back-pressure: the receiver holds off
        // while short scans keep coming, so the output register fills
        // and the input stalls. Pause the sender until all tokens are in.
        random_phase(0, 0);
        hold_asked = 1'b1;
        repeat (30)
        begin
            if ($urandom_range(2) == 0)
                scan_text(WANT_NONE, "/**/");
            else
                scan_text(WANT_NONE, "x");
        end
        send_queue();
        wait_drained();

        random_phase(69, 0);
        random_phase(0, 69);
        random_phase(14, 14);

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
sv/rlcs_pkg.sv
sv/rlcs_if.sv
sv/real_literal_and_comment_scanner.sv
bench/real_literal_and_comment_scanner_tb.sv
